// ===== rtl/pmsd_pkg.sv =====
// Shared constants and types for the PID motor speed drive.
package pmsd_pkg;

  localparam int unsigned DivW = 40;
  localparam int unsigned DsrW = 32;
  localparam int unsigned MulAW = 34;
  localparam int unsigned MulBW = 32;
  localparam int unsigned MulPW = MulAW + MulBW;
  localparam int unsigned CntW = $clog2(DivW);

  localparam logic [2:0] REG_GAIN_P = 3'd0;
  localparam logic [2:0] REG_GAIN_I = 3'd1;
  localparam logic [2:0] REG_GAIN_D = 3'd2;
  localparam logic [2:0] REG_DRIVE_MAX = 3'd3;
  localparam logic [2:0] REG_DRIVE_MIN = 3'd4;
  localparam logic [2:0] REG_MIN_SPEED = 3'd5;
  localparam logic [2:0] REG_DEADZONE = 3'd6;
  localparam logic [2:0] REG_BUMP = 3'd7;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD = 2'd1;
  localparam logic [1:0] DIR_REV = 2'd2;

  localparam logic [7:0] DUTY_FULL = 8'd255;

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_ERR    = 14'b00000000000010,
    ST_PROD   = 14'b00000000000100,
    ST_INTEG  = 14'b00000000001000,
    ST_GLO    = 14'b00000000010000,
    ST_GHI    = 14'b00000000100000,
    ST_GACC   = 14'b00000001000000,
    ST_GSUM   = 14'b00000010000000,
    ST_DWAIT  = 14'b00000100000000,
    ST_CLAMP  = 14'b00001000000000,
    ST_DUTY   = 14'b00010000000000,
    ST_DDIV   = 14'b00100000000000,
    ST_DWAIT2 = 14'b01000000000000,
    ST_DONE   = 14'b10000000000000
  } state_t;

  typedef struct packed {
    logic start;
    logic [DivW-1:0] dividend;
    logic [DsrW-1:0] divisor;
  } div_req_t;

endpackage

// ===== rtl/pid_motor_speed_drive.sv =====
// PID motor speed drive: sequencer around one shared multiplier and one divider.
//
//   channel | ports                                              | direction
//   in      | in_valid/in_ready, target, measured speed, step_ms | sink
//   out     | out_valid/out_ready, drive_value, duty, direction  | source
//   cfg     | cfg_we, cfg_index, cfg_wdata                       | sink
//
// Each item makes two passes through the divider (derivative rate, then
// duty scaling), and the sequencer waits for each pass to finish.
// Reset is synchronous and clears the error and integral history.
// in_ready is high only while the sequencer is idle. A finished result
// waits in the output register; the next item may be taken meanwhile.
module pid_motor_speed_drive (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [31:0] in_target_speed,
  input  logic signed [31:0] in_measured_speed,
  input  logic [15:0] in_step_ms,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [31:0] out_drive_value,
  output logic [7:0] out_duty,
  output logic [1:0] out_direction,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam logic signed [65:0] IntegLim = 66'sd1 <<< 62;
  localparam logic [79:0] TermLim = 80'd1 << 60;

  pmsd_pkg::state_t state_r, state_nxt;

  logic [31:0] gain_p_r, gain_i_r, gain_d_r;
  logic [30:0] drive_max_r, min_speed_r;
  logic signed [31:0] drive_min_r;
  logic [7:0] deadzone_r, bump_r;

  logic signed [31:0] tgt_r, tgt_nxt, meas_r, meas_nxt;
  logic [15:0] dt_r, dt_nxt;
  logic signed [32:0] e_r, e_nxt, last_err_r, last_err_nxt;
  logic signed [63:0] last_integ_r, last_integ_nxt, integ_r, integ_nxt;
  logic [62:0] mag_r, mag_nxt;
  logic neg_r, neg_nxt, dneg_r, dneg_nxt;
  logic [1:0] k_r, k_nxt;
  logic [95:0] acc_r, acc_nxt;
  logic signed [63:0] dacc_r, dacc_nxt;
  logic signed [31:0] drive_r, drive_nxt;
  logic [7:0] duty_r, duty_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [31:0] out_drive_r, out_drive_nxt;
  logic [7:0] out_duty_r, out_duty_nxt;
  logic [1:0] out_dir_r, out_dir_nxt;

  logic [pmsd_pkg::MulAW-1:0] mul_a;
  logic [pmsd_pkg::MulBW-1:0] mul_b;
  logic [pmsd_pkg::MulPW-1:0] mul_p;
  pmsd_pkg::div_req_t div_req;
  logic div_busy;
  logic [pmsd_pkg::DivW-1:0] div_q;

  // Combinational helpers
  logic signed [31:0] ms_s, t_adj;
  logic signed [33:0] sum_s, diff_s;
  logic [33:0] sum_mag, diff_mag;
  logic signed [65:0] prod_s, half_s, integ_sum;
  logic [79:0] sh;
  logic [60:0] term_mag;
  logic signed [63:0] term_s, dv;
  logic [31:0] drv_mag;
  logic [31:0] gain_sel;
  logic [7:0] dq;
  logic hold;

  pmsd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));
  pmsd_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .busy(div_busy), .quotient(div_q));

  assign in_ready = (state_r == pmsd_pkg::ST_IDLE);

  always_comb begin
    ms_s = {1'b0, min_speed_r};
    t_adj = in_target_speed;
    if (in_target_speed > 32'sd0 && in_target_speed < ms_s) begin
      t_adj = ms_s;
    end else if (in_target_speed < 32'sd0 && in_target_speed > -ms_s) begin
      t_adj = -ms_s;
    end

    sum_s = {e_r[32], e_r} + {last_err_r[32], last_err_r};
    diff_s = {e_r[32], e_r} - {last_err_r[32], last_err_r};
    sum_mag = sum_s[33] ? 34'(-sum_s) : 34'(sum_s);
    diff_mag = diff_s[33] ? 34'(-diff_s) : 34'(diff_s);

    prod_s = neg_r ? -$signed(mul_p) : $signed(mul_p);
    half_s = prod_s >>> 1;
    integ_sum = {{2{last_integ_r[63]}}, last_integ_r} + half_s;

    sh = acc_r[95:16];
    term_mag = (sh > TermLim) ? TermLim[60:0] : sh[60:0];
    term_s = neg_r ? -$signed({3'b0, term_mag}) : $signed({3'b0, term_mag});

    case (k_r)
      2'd0: gain_sel = gain_p_r;
      2'd1: gain_sel = gain_i_r;
      default: gain_sel = gain_d_r;
    endcase

    hold = 1'b0;
    dv = dacc_r;
    if (dv > $signed({33'b0, drive_max_r})) begin
      dv = {33'b0, drive_max_r};
      hold = 1'b1;
    end
    if (dv < 64'(drive_min_r)) begin
      dv = 64'(drive_min_r);
      hold = 1'b1;
    end
    if ((tgt_r > 32'sd0 && dv < 64'sd0) || (tgt_r < 32'sd0 && dv > 64'sd0)) begin
      dv = '0;
    end

    drv_mag = drive_r[31] ? 32'(-drive_r) : 32'(drive_r);
    if (drive_max_r == '0) begin
      dq = (drv_mag != '0) ? pmsd_pkg::DUTY_FULL : 8'd0;
    end else begin
      dq = (div_q > 40'(pmsd_pkg::DUTY_FULL)) ? pmsd_pkg::DUTY_FULL : div_q[7:0];
    end
    if (dq <= deadzone_r) begin
      dq = 8'd0;
    end else if (dq <= bump_r) begin
      dq = bump_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    tgt_nxt = tgt_r;
    meas_nxt = meas_r;
    dt_nxt = dt_r;
    e_nxt = e_r;
    last_err_nxt = last_err_r;
    last_integ_nxt = last_integ_r;
    integ_nxt = integ_r;
    mag_nxt = mag_r;
    neg_nxt = neg_r;
    dneg_nxt = dneg_r;
    k_nxt = k_r;
    acc_nxt = acc_r;
    dacc_nxt = dacc_r;
    drive_nxt = drive_r;
    duty_nxt = duty_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_drive_nxt = out_drive_r;
    out_duty_nxt = out_duty_r;
    out_dir_nxt = out_dir_r;
    mul_a = '0;
    mul_b = '0;
    div_req = '0;

    unique case (state_r)
      pmsd_pkg::ST_IDLE: begin
        if (in_valid) begin
          tgt_nxt = t_adj;
          meas_nxt = in_measured_speed;
          dt_nxt = (in_step_ms == '0) ? 16'd1 : in_step_ms;
          state_nxt = pmsd_pkg::ST_ERR;
        end
      end
      pmsd_pkg::ST_ERR: begin
        e_nxt = {tgt_r[31], tgt_r} - {meas_r[31], meas_r};
        dacc_nxt = '0;
        state_nxt = pmsd_pkg::ST_PROD;
      end
      pmsd_pkg::ST_PROD: begin
        mul_a = sum_mag;
        mul_b = {16'b0, dt_r};
        neg_nxt = sum_s[33];
        dneg_nxt = diff_s[33];
        div_req.start = 1'b1;
        div_req.dividend = {6'b0, diff_mag};
        div_req.divisor = {16'b0, dt_r};
        state_nxt = pmsd_pkg::ST_INTEG;
      end
      pmsd_pkg::ST_INTEG: begin
        if (integ_sum > IntegLim) begin
          integ_nxt = IntegLim[63:0];
        end else if (integ_sum < -IntegLim) begin
          integ_nxt = 64'(-IntegLim);
        end else begin
          integ_nxt = integ_sum[63:0];
        end
        mag_nxt = {30'b0, (e_r[32] ? 33'(-e_r) : 33'(e_r))};
        neg_nxt = e_r[32];
        k_nxt = 2'd0;
        state_nxt = pmsd_pkg::ST_GLO;
      end
      pmsd_pkg::ST_GLO: begin
        mul_a = {2'b0, mag_r[31:0]};
        mul_b = gain_sel;
        state_nxt = pmsd_pkg::ST_GHI;
      end
      pmsd_pkg::ST_GHI: begin
        acc_nxt = {30'b0, mul_p};
        mul_a = {3'b0, mag_r[62:32]};
        mul_b = gain_sel;
        state_nxt = pmsd_pkg::ST_GACC;
      end
      pmsd_pkg::ST_GACC: begin
        acc_nxt = acc_r + {mul_p[63:0], 32'b0};
        state_nxt = pmsd_pkg::ST_GSUM;
      end
      pmsd_pkg::ST_GSUM: begin
        dacc_nxt = dacc_r + term_s;
        if (k_r == 2'd0) begin
          mag_nxt = integ_r[63] ? 63'(-integ_r) : integ_r[62:0];
          neg_nxt = integ_r[63];
          k_nxt = 2'd1;
          state_nxt = pmsd_pkg::ST_GLO;
        end else if (k_r == 2'd1) begin
          state_nxt = pmsd_pkg::ST_DWAIT;
        end else begin
          state_nxt = pmsd_pkg::ST_CLAMP;
        end
      end
      pmsd_pkg::ST_DWAIT: begin
        if (!div_busy) begin
          mag_nxt = {29'b0, div_q[33:0]};
          neg_nxt = dneg_r;
          k_nxt = 2'd2;
          state_nxt = pmsd_pkg::ST_GLO;
        end
      end
      pmsd_pkg::ST_CLAMP: begin
        drive_nxt = dv[31:0];
        last_integ_nxt = hold ? last_integ_r : integ_r;
        last_err_nxt = e_r;
        state_nxt = pmsd_pkg::ST_DUTY;
      end
      pmsd_pkg::ST_DUTY: begin
        mul_a = {2'b0, drv_mag};
        mul_b = 32'(pmsd_pkg::DUTY_FULL);
        state_nxt = pmsd_pkg::ST_DDIV;
      end
      pmsd_pkg::ST_DDIV: begin
        div_req.start = 1'b1;
        div_req.dividend = mul_p[39:0];
        div_req.divisor = {1'b0, drive_max_r};
        state_nxt = pmsd_pkg::ST_DWAIT2;
      end
      pmsd_pkg::ST_DWAIT2: begin
        if (!div_busy) begin
          duty_nxt = dq;
          state_nxt = pmsd_pkg::ST_DONE;
        end
      end
      pmsd_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_drive_nxt = drive_r;
          out_duty_nxt = duty_r;
          out_dir_nxt = drive_r[31] ? pmsd_pkg::DIR_REV :
                        ((drive_r != '0) ? pmsd_pkg::DIR_FWD : pmsd_pkg::DIR_STOP);
          state_nxt = pmsd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pmsd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pmsd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      last_err_r <= '0;
      last_integ_r <= '0;
      gain_p_r <= 32'd65536;
      gain_i_r <= '0;
      gain_d_r <= '0;
      drive_max_r <= 31'd16711680;
      drive_min_r <= -32'sd16711680;
      min_speed_r <= '0;
      deadzone_r <= 8'd2;
      bump_r <= 8'd12;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_err_r <= last_err_nxt;
      last_integ_r <= last_integ_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          pmsd_pkg::REG_GAIN_P: gain_p_r <= cfg_wdata;
          pmsd_pkg::REG_GAIN_I: gain_i_r <= cfg_wdata;
          pmsd_pkg::REG_GAIN_D: gain_d_r <= cfg_wdata;
          pmsd_pkg::REG_DRIVE_MAX: drive_max_r <= cfg_wdata[30:0];
          pmsd_pkg::REG_DRIVE_MIN: drive_min_r <= cfg_wdata;
          pmsd_pkg::REG_MIN_SPEED: min_speed_r <= cfg_wdata[30:0];
          pmsd_pkg::REG_DEADZONE: deadzone_r <= cfg_wdata[7:0];
          pmsd_pkg::REG_BUMP: bump_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
    tgt_r <= tgt_nxt;
    meas_r <= meas_nxt;
    dt_r <= dt_nxt;
    e_r <= e_nxt;
    integ_r <= integ_nxt;
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    dneg_r <= dneg_nxt;
    k_r <= k_nxt;
    acc_r <= acc_nxt;
    dacc_r <= dacc_nxt;
    drive_r <= drive_nxt;
    duty_r <= duty_nxt;
    out_drive_r <= out_drive_nxt;
    out_duty_r <= out_duty_nxt;
    out_dir_r <= out_dir_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_drive_value = out_drive_r;
  assign out_duty = out_duty_r;
  assign out_direction = out_dir_r;

  // The divider is never restarted while a division is still running.
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

  // The stored integral stays inside its saturation range.
  a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
    (last_integ_r <= 64'sd4611686018427387904) &&
    (last_integ_r >= -64'sd4611686018427387904))
    else $error("integral out of range");

  // A new beat appears only when the sequencer leaves its final state.
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == pmsd_pkg::ST_DONE))
    else $error("result without completed step");

  // A stopped drive always carries a zero duty.
  a_stop_duty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dir_r == pmsd_pkg::DIR_STOP) |-> (out_duty_r == 8'd0))
    else $error("nonzero duty with stopped drive");

endmodule

// ===== rtl/pmsd_mul.sv =====
// Registered unsigned multiplier shared by every product of the drive.
module pmsd_mul (
  input  logic clk,
  input  logic [pmsd_pkg::MulAW-1:0] a,
  input  logic [pmsd_pkg::MulBW-1:0] b,
  output logic [pmsd_pkg::MulPW-1:0] p
);

  logic [pmsd_pkg::MulPW-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= pmsd_pkg::MulPW'(a) * pmsd_pkg::MulPW'(b);
  end

  assign p = p_r;

endmodule

// ===== rtl/pmsd_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module pmsd_div (
  input  logic clk,
  input  logic rst_n,
  input  pmsd_pkg::div_req_t req,
  output logic busy,
  output logic [pmsd_pkg::DivW-1:0] quotient
);

  logic busy_r, busy_nxt;
  logic [pmsd_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic [pmsd_pkg::DivW-1:0] q_r, q_nxt;
  logic [pmsd_pkg::DsrW-1:0] rem_r, rem_nxt;
  logic [pmsd_pkg::DsrW-1:0] dsr_r, dsr_nxt;
  logic [pmsd_pkg::DsrW:0] trial;
  logic [pmsd_pkg::DsrW:0] diff;
  logic ge;

  always_comb begin
    trial = {rem_r, q_r[pmsd_pkg::DivW-1]};
    ge = trial >= {1'b0, dsr_r};
    diff = trial - {1'b0, dsr_r};
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt = pmsd_pkg::CntW'(pmsd_pkg::DivW - 1);
      q_nxt = req.dividend;
      rem_nxt = '0;
      dsr_nxt = req.divisor;
    end else if (busy_r) begin
      q_nxt = {q_r[pmsd_pkg::DivW-2:0], ge};
      rem_nxt = ge ? diff[pmsd_pkg::DsrW-1:0] : trial[pmsd_pkg::DsrW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy = busy_r;
  assign quotient = q_r;

endmodule
